FILE: hdl/trt_pkg.sv
// Shared constants, types and register codes for the TCP receive reassembly tracker.
`default_nettype none

package trt_pkg;

    // Number of out-of-order segments the reassembly table can hold.
    localparam int TABLE_ENTRIES = 16;

    localparam int TBL_IDX_W = $clog2(TABLE_ENTRIES);
    localparam int MISS_W    = $clog2(TABLE_ENTRIES + 1);

    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 16;
    localparam int ENTRY_W = SEQ_W + LEN_W;

    localparam logic [TBL_IDX_W-1:0] LAST_IDX    = TBL_IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [MISS_W-1:0]    MISS_LIMIT  = MISS_W'(TABLE_ENTRIES);

    localparam logic [SEQ_W-1:0] BUFFER_SIZE_RST = 32'd8192;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ACK_SEQ = 1'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FREE,
        S_STORE,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/trt_ifs.sv
// Valid/ready channel interfaces for arriving segments and outgoing acks.
`default_nettype none

interface trt_seg_if import trt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] segment_start;
    logic [LEN_W-1:0] segment_length;

    modport source (output valid, output segment_start, output segment_length, input ready);
    modport sink   (input valid, input segment_start, input segment_length, output ready);
endinterface

interface trt_ack_if import trt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] cumulative_ack;
    logic [SEQ_W-1:0] received_bytes;
    logic [SEQ_W-1:0] sack_echo;
    logic [SEQ_W-1:0] ack_seq;
    logic             table_overflow;
    logic             transfer_done;

    modport source (output valid, output cumulative_ack, output received_bytes,
                    output sack_echo, output ack_seq, output table_overflow,
                    output transfer_done, input ready);
    modport sink   (input valid, input cumulative_ack, input received_bytes,
                    input sack_echo, input ack_seq, input table_overflow,
                    input transfer_done, output ready);
endinterface

`default_nettype wire

FILE: hdl/trt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module trt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/tcp_receive_reassembly_tracker.sv
// Top level of the TCP receive reassembly tracker: sequencer, state and table.
//
//   Channel   Dir  Handshake          Payload
//   i_seg     in   valid / ready      segment_start, segment_length
//   o_ack     out  valid / ready      cumulative_ack, received_bytes, sack_echo,
//                                     ack_seq, table_overflow, transfer_done
//   i_cfg_*   in   write enable only  register index, 32-bit data
//
// An item's time is set by the single read port of the segment table, which is
// swept one entry per cycle: in the chain walk, until a full lap finds no entry
// that starts at the expected index, and once more in the cleanup pass.
// Reset (synchronous, active low) empties the table by clearing its valid bits.
// An item is taken only in the idle state. A stalled ack does not stop the next
// item from being worked through; the sequencer then waits in its output state
// until the ack register frees up. Items after completion are taken and dropped.
`default_nettype none

module tcp_receive_reassembly_tracker import trt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    trt_seg_if.sink                   i_seg,
    trt_ack_if.source                 o_ack,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [SEQ_W-1:0]     i_cfg_data
);

    // Sequencer state and the block's architectural state.
    t_state                 r_state,     n_state;
    logic [SEQ_W-1:0]       r_count,     n_count;
    logic [SEQ_W-1:0]       r_ack_ctr,   n_ack_ctr;
    logic [SEQ_W-1:0]       r_buf_size,  n_buf_size;
    logic                   r_finished,  n_finished;
    logic [TABLE_ENTRIES-1:0] r_valid,   n_valid;

    // Per-item working registers.
    logic [SEQ_W-1:0]       r_start,     n_start;
    logic [LEN_W-1:0]       r_len,       n_len;
    logic [TBL_IDX_W-1:0]   r_idx,       n_idx;
    logic [TBL_IDX_W-1:0]   r_idx_d,     n_idx_d;
    logic                   r_rd_vld,    n_rd_vld;
    logic                   r_issue_done, n_issue_done;
    logic [MISS_W-1:0]      r_miss,      n_miss;
    logic                   r_dup,       n_dup;
    logic                   r_found,     n_found;
    logic [TBL_IDX_W-1:0]   r_slot,      n_slot;
    logic                   r_ovf,       n_ovf;

    // Output register.
    logic                   r_o_valid,   n_o_valid;
    logic [SEQ_W-1:0]       r_o_cum,     n_o_cum;
    logic [SEQ_W-1:0]       r_o_recv,    n_o_recv;
    logic [SEQ_W-1:0]       r_o_echo,    n_o_echo;
    logic [SEQ_W-1:0]       r_o_seq,     n_o_seq;
    logic                   r_o_ovf,     n_o_ovf;
    logic                   r_o_done,    n_o_done;

    // Table RAM signals.
    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [SEQ_W-1:0]       rd_start;
    logic [LEN_W-1:0]       rd_len;

    // The expected index always equals the in-order count plus one.
    logic [SEQ_W-1:0]       exp_idx;
    logic                   entry_live;
    logic                   stale;
    logic                   done_now;
    logic [MISS_W-1:0]      miss_inc;

    assign exp_idx    = r_count + SEQ_W'(1);
    assign rd_start   = ram_rdata[ENTRY_W-1:LEN_W];
    assign rd_len     = ram_rdata[LEN_W-1:0];
    assign entry_live = r_rd_vld && r_valid[r_idx_d];
    assign stale      = entry_live && (rd_start < exp_idx);
    assign done_now   = (r_count >= r_buf_size);
    assign miss_inc   = r_miss + MISS_W'(1);

    trt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata ({r_start, r_len}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign i_seg.ready           = (r_state == S_IDLE);
    assign o_ack.valid           = r_o_valid;
    assign o_ack.cumulative_ack  = r_o_cum;
    assign o_ack.received_bytes  = r_o_recv;
    assign o_ack.sack_echo       = r_o_echo;
    assign o_ack.ack_seq         = r_o_seq;
    assign o_ack.table_overflow  = r_o_ovf;
    assign o_ack.transfer_done   = r_o_done;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ack_ctr    = r_ack_ctr;
        n_buf_size   = r_buf_size;
        n_finished   = r_finished;
        n_valid      = r_valid;
        n_start      = r_start;
        n_len        = r_len;
        n_idx        = r_idx;
        n_idx_d      = r_idx_d;
        n_rd_vld     = 1'b0;
        n_issue_done = r_issue_done;
        n_miss       = r_miss;
        n_dup        = r_dup;
        n_found      = r_found;
        n_slot       = r_slot;
        n_ovf        = r_ovf;
        n_o_valid    = r_o_valid && !o_ack.ready;
        n_o_cum      = r_o_cum;
        n_o_recv     = r_o_recv;
        n_o_echo     = r_o_echo;
        n_o_seq      = r_o_seq;
        n_o_ovf      = r_o_ovf;
        n_o_done     = r_o_done;
        ram_we       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_seg.valid && !r_finished) begin
                    n_start      = i_seg.segment_start;
                    n_len        = i_seg.segment_length;
                    if (i_seg.segment_start == exp_idx) begin
                        n_count = r_count + SEQ_W'(i_seg.segment_length);
                    end
                    n_idx        = '0;
                    n_miss       = '0;
                    n_state      = S_WALK;
                end
            end

            S_WALK: begin
                // Sweep the table circularly; the walk ends once a full lap
                // finds nothing that starts at the expected index.
                n_idx    = (r_idx == LAST_IDX) ? '0 : r_idx + TBL_IDX_W'(1);
                n_idx_d  = r_idx;
                n_rd_vld = 1'b1;
                if (r_rd_vld) begin
                    if (entry_live && rd_start == exp_idx && rd_len != '0) begin
                        n_count = r_count + SEQ_W'(rd_len);
                        n_miss  = '0;
                    end else begin
                        n_miss  = miss_inc;
                    end
                    // A matching zero-length entry ends the chain as well.
                    if ((entry_live && rd_start == exp_idx && rd_len == '0)
                            || (!(entry_live && rd_start == exp_idx)
                                && miss_inc == MISS_LIMIT)) begin
                        n_state      = S_FREE;
                        n_idx        = '0;
                        n_rd_vld     = 1'b0;
                        n_issue_done = 1'b0;
                        n_dup        = 1'b0;
                        n_found      = 1'b0;
                        n_slot       = '0;
                    end
                end
            end

            S_FREE: begin
                // One ordered pass: drop stale entries, look for a duplicate
                // start and pick the lowest free slot.
                if (!r_issue_done) begin
                    n_idx_d  = r_idx;
                    n_rd_vld = 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_idx = r_idx + TBL_IDX_W'(1);
                    end
                end
                if (r_rd_vld) begin
                    if (stale) begin
                        n_valid[r_idx_d] = 1'b0;
                    end
                    if (entry_live && !stale && rd_start == r_start) begin
                        n_dup = 1'b1;
                    end
                    if ((!entry_live || stale) && !r_found) begin
                        n_found = 1'b1;
                        n_slot  = r_idx_d;
                    end
                    if (r_idx_d == LAST_IDX) begin
                        n_state = S_STORE;
                    end
                end
            end

            S_STORE: begin
                n_ack_ctr = r_ack_ctr + SEQ_W'(1);
                n_ovf     = 1'b0;
                if (r_start >= exp_idx && !r_dup) begin
                    if (r_found) begin
                        ram_we          = 1'b1;
                        n_valid[r_slot] = 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                n_state = S_OUT;
            end

            S_OUT: begin
                if (!r_o_valid || o_ack.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_cum    = exp_idx;
                    n_o_recv   = r_count;
                    n_o_echo   = r_start;
                    n_o_seq    = r_ack_ctr;
                    n_o_ovf    = r_ovf;
                    n_o_done   = done_now;
                    n_finished = done_now;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUFFER_SIZE: begin
                    n_buf_size = i_cfg_data;
                end
                CFG_INITIAL_ACK_SEQ: begin
                    n_ack_ctr = i_cfg_data;
                end
                default: begin
                    n_buf_size = r_buf_size;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_ack_ctr  <= '0;
            r_buf_size <= BUFFER_SIZE_RST;
            r_finished <= 1'b0;
            r_valid    <= '0;
            r_rd_vld   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ack_ctr  <= n_ack_ctr;
            r_buf_size <= n_buf_size;
            r_finished <= n_finished;
            r_valid    <= n_valid;
            r_rd_vld   <= n_rd_vld;
            r_o_valid  <= n_o_valid;
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_start      <= n_start;
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_idx_d      <= n_idx_d;
        r_issue_done <= n_issue_done;
        r_miss       <= n_miss;
        r_dup        <= n_dup;
        r_found      <= n_found;
        r_slot       <= n_slot;
        r_ovf        <= n_ovf;
        r_o_cum      <= n_o_cum;
        r_o_recv     <= n_o_recv;
        r_o_echo     <= n_o_echo;
        r_o_seq      <= n_o_seq;
        r_o_ovf      <= n_o_ovf;
        r_o_done     <= n_o_done;
    end

endmodule

`default_nettype wire

FILE: hdl/trt_chk.sv
// Port-level checks on the TCP receive reassembly tracker, bound to the top level.
`default_nettype none

module trt_chk import trt_pkg::*; (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_seg_valid,
    input wire logic             i_seg_ready,
    input wire logic             i_ack_valid,
    input wire logic             i_ack_ready,
    input wire logic [SEQ_W-1:0] i_ack_cum,
    input wire logic [SEQ_W-1:0] i_ack_recv,
    input wire logic             i_ack_done
);

    // An ack offered to a stalled sink stays offered.
    a_ack_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ack_valid && !i_ack_ready |=> i_ack_valid)
        else $error("ack withdrawn while stalled");

    // The cumulative ack is always one past the in-order byte count.
    a_ack_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ack_valid |-> (i_ack_cum == i_ack_recv + 32'd1))
        else $error("cumulative ack does not match received byte count");

    // Once the final ack has been taken, no further ack is offered at once.
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ack_valid && i_ack_ready && i_ack_done |=> !i_ack_valid)
        else $error("ack offered right after transfer completion");

    // An item needs its table walk, cleanup pass and store before its ack can appear.
    a_no_instant_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_seg_valid && i_seg_ready |=> !$rose(i_ack_valid))
        else $error("ack appeared one cycle after an item was taken");

endmodule

bind tcp_receive_reassembly_tracker trt_chk u_trt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_seg_valid (i_seg.valid),
    .i_seg_ready (i_seg.ready),
    .i_ack_valid (o_ack.valid),
    .i_ack_ready (o_ack.ready),
    .i_ack_cum   (o_ack.cumulative_ack),
    .i_ack_recv  (o_ack.received_bytes),
    .i_ack_done  (o_ack.transfer_done)
);

`default_nettype wire
